// ----- rtl/uers_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package uers_pkg;

  localparam int unsigned NumSensors = 3;

  localparam int unsigned CountW   = 12;
  localparam int unsigned StepW    = 4;
  localparam int unsigned TrigW    = 4;
  localparam int unsigned GapW     = 8;
  localparam int unsigned TimerW   = 8;
  localparam int unsigned SensorW  = 2;
  localparam int unsigned ProductW = CountW + StepW;
  localparam int unsigned DistW    = 11;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned CfgIdxW  = 2;

  // distance = product / 58 as (product * DivMul) >> DivShift, exact for 16-bit products
  localparam int unsigned DivMulW  = 17;
  localparam int unsigned DivShift = 22;
  localparam logic [DivMulW-1:0] DivMul = DivMulW'((64'd1 << DivShift) / 58 + 1);
  localparam int unsigned DivProdW = ProductW + DivMulW;

  localparam logic [CountW-1:0] CountLimitRst   = CountW'(848);
  localparam logic [StepW-1:0]  StepUsRst       = StepW'(10);
  localparam logic [TrigW-1:0]  TriggerTicksRst = TrigW'(2);
  localparam logic [GapW-1:0]   GapTicksRst     = GapW'(50);

  localparam logic [CfgIdxW-1:0] RegCountLimit   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStepUs       = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTriggerTicks = 2'd2;
  localparam logic [CfgIdxW-1:0] RegGapTicks     = 2'd3;

  localparam logic [SensorW-1:0] SensorFront = 2'd0;
  localparam logic [SensorW-1:0] SensorRight = 2'd1;
  localparam logic [SensorW-1:0] SensorLeft  = 2'd2;
  localparam logic [SensorW-1:0] SensorLast  = SensorW'(NumSensors - 1);

  typedef enum logic [1:0] {
    PH_TRIG,
    PH_WAIT,
    PH_COUNT,
    PH_GAP
  } phase_e;

  typedef struct packed {
    logic [CountW-1:0] count_limit;
    logic [StepW-1:0]  step_us;
    logic [TrigW-1:0]  trigger_ticks;
    logic [GapW-1:0]   gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]          trig;
    logic                valid;
    logic [SensorW-1:0]  sensor;
    logic [ProductW-1:0] product;
  } step_res_t;

endpackage
`default_nettype wire

// ----- rtl/uers_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module uers_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [2:0]        echo_i,
  input  wire uers_pkg::cfg_t    cfg_i,
  output uers_pkg::step_res_t    res_o
);
  import uers_pkg::*;

  phase_e              phase_q, phase_d;
  logic [SensorW-1:0]  sensor_q, sensor_d;
  logic [TimerW-1:0]   timer_q, timer_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [TimerW-1:0]   timer_inc;
  logic                echo;
  logic                finish;

  assign timer_inc = timer_q + TimerW'(1);

  always_comb begin
    case (sensor_q)
      SensorRight: echo = echo_i[1];
      SensorLeft:  echo = echo_i[2];
      default:     echo = echo_i[0];
    endcase
  end

  always_comb begin
    case (phase_q)
      PH_WAIT:  finish = echo && (cfg_i.count_limit == '0);
      PH_COUNT: finish = !(echo && (count_q < cfg_i.count_limit));
      default:  finish = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    phase_d  = phase_q;
    sensor_d = sensor_q;
    timer_d  = timer_q;
    count_d  = count_q;
    case (phase_q)
      PH_TRIG: begin
        if (timer_inc >= TimerW'(cfg_i.trigger_ticks)) begin
          timer_d = '0;
          phase_d = PH_WAIT;
        end else begin
          timer_d = timer_inc;
        end
      end
      PH_WAIT: begin
        if (echo && !finish) begin
          count_d = CountW'(1);
          phase_d = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (!finish) begin
          count_d = count_q + CountW'(1);
        end
      end
      PH_GAP: begin
        if (timer_inc >= cfg_i.gap_ticks) begin
          timer_d = '0;
          phase_d = PH_TRIG;
        end else begin
          timer_d = timer_inc;
        end
      end
      default: phase_d = PH_TRIG;
    endcase
    if (finish) begin
      count_d = '0;
      timer_d = '0;
      if (sensor_q >= SensorLast) begin
        sensor_d = '0;
        phase_d  = (cfg_i.gap_ticks == '0) ? PH_TRIG : PH_GAP;
      end else begin
        sensor_d = sensor_q + SensorW'(1);
        phase_d  = PH_TRIG;
      end
    end
  end

  // outputs
  always_comb begin
    res_o = '0;
    case (phase_q)
      PH_TRIG: begin
        case (sensor_q)
          SensorRight: res_o.trig = 3'b010;
          SensorLeft:  res_o.trig = 3'b100;
          default:     res_o.trig = 3'b001;
        endcase
      end
      default: res_o.trig = 3'b000;
    endcase
    if (finish) begin
      res_o.valid   = 1'b1;
      res_o.sensor  = (sensor_q >= SensorW'(NumSensors)) ? SensorFront : sensor_q;
      res_o.product = (phase_q == PH_COUNT) ? (ProductW'(count_q) * ProductW'(cfg_i.step_us))
                                            : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TRIG;
      sensor_q <= '0;
      timer_q  <= '0;
      count_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      sensor_q <= sensor_d;
      timer_q  <= timer_d;
      count_q  <= count_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/uers_div58.sv -----
`timescale 1ns / 1ps
`default_nettype none
module uers_div58 (
  input  wire logic [uers_pkg::ProductW-1:0] product_i,
  output logic [uers_pkg::DistW-1:0]         dist_o
);
  import uers_pkg::*;

  logic [DivProdW-1:0] scaled;

  assign scaled = DivProdW'(product_i) * DivProdW'(DivMul);
  assign dist_o = scaled[DivShift +: DistW];

endmodule
`default_nettype wire

// ----- rtl/ultrasonic_echo_ranging_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Three-sensor ultrasonic ranging sequencer. Each input transaction is one timing step carrying
// the echo levels of the front, right and left sensors; each one yields exactly one output
// transaction with the trigger levels for that step and, when a measurement finished, the
// sensor and its distance in cm (echo steps * step_us / 58, truncated). Sensors are fired in
// the order front, right, left, then gap_ticks idle steps. One transaction is accepted per
// clock unless m_axis_tready back-pressure stalls the pipeline: the input register, the
// sequencer/product stage and the divide-by-58 result register form a three-stage pipeline.
// Configuration writes take effect on the next accepted step and should be made when idle.
module ultrasonic_echo_ranging_sequencer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // echo_front, echo_right, echo_left
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [15:0]                        m_axis_tdata,  // trig_front, trig_right, trig_left,
                                                            // distance_cm
  output logic [2:0]                         m_axis_tuser,  // result_valid, result_sensor
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [uers_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [uers_pkg::CfgDataW-1:0] cfg_data_i
);
  import uers_pkg::*;

  cfg_t               cfg_q;
  logic               in_v_q;
  logic [2:0]         echo_q;
  logic               mid_v_q;
  step_res_t          mid_q;
  step_res_t          step_res;
  logic               out_v_q;
  logic [2:0]         trig_q;
  logic               valid_q;
  logic [SensorW-1:0] sensor_q;
  logic [DistW-1:0]   dist_q;
  logic [DistW-1:0]   dist_cm;
  logic               rdy_out, rdy_mid, rdy_in;
  logic               step;

  assign rdy_out = !out_v_q || m_axis_tready;
  assign rdy_mid = !mid_v_q || rdy_out;
  assign rdy_in  = !in_v_q || rdy_mid;
  assign step    = in_v_q && rdy_mid;

  assign s_axis_tready = rdy_in;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.count_limit   <= CountLimitRst;
      cfg_q.step_us       <= StepUsRst;
      cfg_q.trigger_ticks <= TriggerTicksRst;
      cfg_q.gap_ticks     <= GapTicksRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegCountLimit:   cfg_q.count_limit   <= cfg_data_i[CountW-1:0];
        RegStepUs:       cfg_q.step_us       <= cfg_data_i[StepW-1:0];
        RegTriggerTicks: cfg_q.trigger_ticks <= cfg_data_i[TrigW-1:0];
        RegGapTicks:     cfg_q.gap_ticks     <= cfg_data_i[GapW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      mid_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy_in) begin
        in_v_q <= s_axis_tvalid;
      end
      if (rdy_mid) begin
        mid_v_q <= in_v_q;
      end
      if (rdy_out) begin
        out_v_q <= mid_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_in && s_axis_tvalid) begin
      echo_q <= s_axis_tdata[2:0];
    end
    if (step) begin
      mid_q <= step_res;
    end
    if (rdy_out && mid_v_q) begin
      trig_q   <= mid_q.trig;
      valid_q  <= mid_q.valid;
      sensor_q <= mid_q.sensor;
      dist_q   <= dist_cm;
    end
  end

  uers_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .echo_i (echo_q),
    .cfg_i  (cfg_q),
    .res_o  (step_res)
  );

  uers_div58 u_div58 (
    .product_i (mid_q.product),
    .dist_o    (dist_cm)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, dist_q, trig_q};
  assign m_axis_tuser  = {sensor_q, valid_q};

endmodule
`default_nettype wire

// ----- sim/ranging_checker.sv -----
`timescale 1ns / 1ps
module ranging_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_valid_i,
  input  logic                          step_ready_i,
  input  logic [7:0]                    step_data_i,   // echo_front, echo_right, echo_left
  input  logic                          res_valid_i,
  input  logic                          res_ready_i,
  input  logic [15:0]                   res_data_i,    // trig_front, trig_right, trig_left,
                                                       // distance_cm
  input  logic [2:0]                    res_user_i,    // result_valid, result_sensor
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [uers_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [uers_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            mismatch_count_o,
  output int                            pending_o
);
  import uers_pkg::*;

  typedef struct packed {
    logic [2:0]         trig;
    logic               valid;
    logic [SensorW-1:0] sensor;
    logic [DistW-1:0]   dist_cm;
  } ranging_t;

  cfg_t               seq_cfg;
  phase_e             seq_phase;
  logic [SensorW-1:0] seq_sensor;
  logic [TimerW-1:0]  seq_timer;
  logic [CountW-1:0]  seq_count;

  ranging_t expected_q[$];
  int       fails;

  function automatic ranging_t step_sequencer(input logic [2:0] echo);
    ranging_t            r;
    logic                echo_hi;
    logic                done;
    logic [ProductW-1:0] product;
    r = '0;
    done = 1'b0;
    echo_hi = echo[seq_sensor];
    case (seq_phase)
      PH_TRIG: begin
        r.trig[seq_sensor] = 1'b1;
        seq_timer = seq_timer + 1'b1;
        if (seq_timer >= TimerW'(seq_cfg.trigger_ticks)) begin
          seq_timer = '0;
          seq_phase = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (echo_hi) begin
          if (seq_cfg.count_limit != '0) begin
            seq_count = CountW'(1);
            seq_phase = PH_COUNT;
          end else begin
            seq_count = '0;
            done = 1'b1;
          end
        end
      end
      PH_COUNT: begin
        if (echo_hi && seq_count < seq_cfg.count_limit) begin
          seq_count = seq_count + 1'b1;
        end else begin
          done = 1'b1;
        end
      end
      default: begin
        seq_timer = seq_timer + 1'b1;
        if (seq_timer >= seq_cfg.gap_ticks) begin
          seq_timer = '0;
          seq_phase = PH_TRIG;
        end
      end
    endcase
    if (done) begin
      product = ProductW'(seq_count) * ProductW'(seq_cfg.step_us);
      r.valid = 1'b1;
      r.sensor = seq_sensor;
      r.dist_cm = DistW'(product / ProductW'(58));
      seq_count = '0;
      seq_timer = '0;
      if (seq_sensor == SensorLast) begin
        seq_sensor = SensorFront;
        seq_phase = (seq_cfg.gap_ticks == '0) ? PH_TRIG : PH_GAP;
      end else begin
        seq_sensor = seq_sensor + 1'b1;
        seq_phase = PH_TRIG;
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input int exp_val, input int got_val);
    fails++;
    if (fails <= 10) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_val, got_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ranging_t got;
    ranging_t exp_r;
    if (!rst_ni) begin
      seq_cfg.count_limit   = CountLimitRst;
      seq_cfg.step_us       = StepUsRst;
      seq_cfg.trigger_ticks = TriggerTicksRst;
      seq_cfg.gap_ticks     = GapTicksRst;
      seq_phase  = PH_TRIG;
      seq_sensor = SensorFront;
      seq_timer  = '0;
      seq_count  = '0;
      expected_q.delete();
      fails = 0;
      mismatch_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        got.trig    = res_data_i[2:0];
        got.dist_cm = res_data_i[3 +: DistW];
        got.valid   = res_user_i[0];
        got.sensor  = res_user_i[2:1];
        if (expected_q.size() == 0) begin
          note_mismatch("unexpected transaction, tdata", 0, res_data_i);
        end else begin
          exp_r = expected_q.pop_front();
          if (got.trig != exp_r.trig) note_mismatch("trig", exp_r.trig, got.trig);
          if (got.valid != exp_r.valid) note_mismatch("result_valid", exp_r.valid, got.valid);
          if (got.sensor != exp_r.sensor) begin
            note_mismatch("result_sensor", exp_r.sensor, got.sensor);
          end
          if (got.dist_cm != exp_r.dist_cm) begin
            note_mismatch("distance_cm", exp_r.dist_cm, got.dist_cm);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegCountLimit:   seq_cfg.count_limit   = cfg_data_i[CountW-1:0];
          RegStepUs:       seq_cfg.step_us       = cfg_data_i[StepW-1:0];
          RegTriggerTicks: seq_cfg.trigger_ticks = cfg_data_i[TrigW-1:0];
          default:         seq_cfg.gap_ticks     = cfg_data_i[GapW-1:0];
        endcase
      end
      if (step_valid_i && step_ready_i) begin
        expected_q.push_back(step_sequencer(step_data_i[2:0]));
      end
      mismatch_count_o <= fails;
      pending_o <= expected_q.size();
    end
  end

endmodule

// ----- sim/ultrasonic_echo_ranging_sequencer_test.sv -----
`timescale 1ns / 1ps
module ultrasonic_echo_ranging_sequencer_test;
  import uers_pkg::*;

  localparam int IdleLimit = 2000;
  // front fires, right fires, left fires with short echoes; first item in the low bits
  localparam logic [65:0] DirectedEcho = {
    3'b011, 3'b100, 3'b100, 3'b000, 3'b000, 3'b000, 3'b010, 3'b000, 3'b000, 3'b110,
    {8{3'b111}}, {4{3'b000}}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // echo_front, echo_right, echo_left
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [15:0]         m_axis_tdata;   // trig_front, trig_right, trig_left, distance_cm
  logic [2:0]          m_axis_tuser;   // result_valid, result_sensor
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int       mismatches;
  int       pending;
  int       idle_cycles;
  int       rx_hold;
  logic     rx_stalls_on;
  logic     tx_idle_on;
  logic [2:0] echo_lvl;

  ultrasonic_echo_ranging_sequencer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  ranging_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_valid_i     (s_axis_tvalid),
    .step_ready_i     (s_axis_tready),
    .step_data_i      (s_axis_tdata),
    .res_valid_i      (m_axis_tvalid),
    .res_ready_i      (m_axis_tready),
    .res_data_i       (m_axis_tdata),
    .res_user_i       (m_axis_tuser),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // result-side backpressure: bursts of stalls, switched on and off now and then
  always @(posedge clk_i) begin
    if ($urandom_range(0, 255) == 0) rx_stalls_on <= ~rx_stalls_on;
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
      rx_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic int tx_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!tx_idle_on || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_step(input logic [2:0] echo);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, echo};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // echo levels as pulses of random length, with some fully random noise steps
  task automatic random_steps(input int n, input int run_len);
    logic [2:0] echo;
    tx_idle_on = ($urandom_range(0, 3) != 0);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        echo = 3'($urandom);
      end else begin
        for (int b = 0; b < 3; b++) begin
          if ($urandom_range(1, run_len) == 1) echo_lvl[b] = ~echo_lvl[b];
        end
        echo = echo_lvl;
      end
      send_step(echo);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [CfgDataW-1:0] limit, input logic [CfgDataW-1:0] step,
                            input logic [CfgDataW-1:0] trig, input logic [CfgDataW-1:0] gap);
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      case (i)
        0: begin
          cfg_index_i <= RegCountLimit;
          cfg_data_i <= limit;
        end
        1: begin
          cfg_index_i <= RegStepUs;
          cfg_data_i <= step;
        end
        2: begin
          cfg_index_i <= RegTriggerTicks;
          cfg_data_i <= trig;
        end
        default: begin
          cfg_index_i <= RegGapTicks;
          cfg_data_i <= gap;
        end
      endcase
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int run_len;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegCountLimit;
    cfg_data_i = '0;
    rx_hold = 0;
    rx_stalls_on = 1'b0;
    tx_idle_on = 1'b0;
    echo_lvl = '0;
    idle_cycles = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 22; i++) send_step(DirectedEcho[3*i +: 3]);
    random_steps(60, 6);
    settle();

    // zero count limit, zero step, zero trigger ticks, no gap
    write_regs(CfgDataW'(0), CfgDataW'(0), CfgDataW'(0), CfgDataW'(0));
    random_steps(40, 4);
    settle();

    write_regs(CfgDataW'(1), CfgDataW'(15), CfgDataW'(1), CfgDataW'(255));
    random_steps(100, 5);
    settle();

    // echo held high long enough to saturate the count limit on every sensor
    write_regs(CfgDataW'(40), CfgDataW'(15), CfgDataW'(15), CfgDataW'(8));
    tx_idle_on = 1'b0;
    repeat (180) send_step(3'b111);
    settle();

    repeat (6) begin
      write_regs(CfgDataW'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                        : $urandom_range(1, 40)),
                 CfgDataW'($urandom_range(0, 15)), CfgDataW'($urandom_range(0, 15)),
                 CfgDataW'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 12)));
      run_len = 2 << (2 * $urandom_range(0, 2));
      random_steps(20, run_len);
      settle();
      random_steps(20, run_len);
      settle();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
